// ===== rtl/core/circular_deque_macros.svh =====
// ----------------------------------------------------------------------------
// Circular deque assertion macros
// Concurrent assertion wrappers used by the deque top module. Under SYNTHESIS
// they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define CD_ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define CD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CD_ASSERT_HOLDS(label, clk, rst_n, prop, msg)
`define CD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/cd_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular deque package
// Field widths, command and status codes and the cell control types.
// ----------------------------------------------------------------------------
`default_nettype none

package cd_pkg;

  localparam int WORD_W      = 32;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 8;

  // Command codes carried by an input beat.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  // Status codes returned with each result beat.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  // Movement of the cell ring at a clock edge.
  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_LEFT  = 2'd1,
    SH_RIGHT = 2'd2
  } shift_t;

  // Broadcast control for every cell of the ring.
  typedef struct packed {
    shift_t shift;
    logic   wr_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/circular_deque.sv =====
// ----------------------------------------------------------------------------
// Circular deque
// Double-ended queue of signed 32-bit words held in a ring of storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (in_command, in_data_in) is taken on a rising edge with
//   start high and busy low. Every beat yields one result beat on out_data_out,
//   out_status and out_count_after, shown for a single cycle with out_valid.
//   The receiver cannot stall; results must be taken as they appear.
// Operation:
//   The words sit packed against one end of the ring, the anchor. Pushes, and
//   pops at the anchored end, finish in the accepting cycle: the result is registered
//   and shows in the next cycle, and a new beat may follow every cycle.
//   With two or more entries held, a pop at the far end rotates the ring one
//   cell per cycle until that word reaches the end cell, with busy high and no
//   new beat taken meanwhile, and the anchor moves over.
// Reset:
//   Synchronous, active low; the deque comes up empty with no result pending.
//   Stored words are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_deque_macros.svh"

module circular_deque #(
  parameter int DEPTH = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic        [cd_pkg::CMD_W-1:0]  in_command,
  input  wire logic signed [cd_pkg::WORD_W-1:0] in_data_in,
  output logic                                  out_valid,
  output logic signed [cd_pkg::WORD_W-1:0]      out_data_out,
  output logic        [cd_pkg::STATUS_W-1:0]    out_status,
  output logic        [cd_pkg::COUNT_OUT_W-1:0] out_count_after
);

  import cd_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_ROTATE
  } state_t;

  // Which end of the ring the words are packed against.
  typedef enum logic {
    ANCHOR_FRONT,
    ANCHOR_REAR
  } anchor_t;

  state_t                  state_r, state_nxt;
  anchor_t                 anchor_r, anchor_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        rem_r, rem_nxt;
  logic                    out_valid_r;
  logic [WORD_W-1:0]       out_data_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [COUNT_OUT_W-1:0]  out_count_r;

  cell_ctrl_t              ctrl;
  logic [IDX_W-1:0]        wr_idx;
  logic [WORD_W-1:0]       tap_first, tap_second, tap_penult, tap_last;

  cmd_t                    cmd;
  logic                    full, empty, done;
  logic [WORD_W-1:0]       res_data;
  logic [STATUS_W-1:0]     res_status;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  assign cmd   = cmd_t'(in_command);
  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);

  cd_chain #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .wr_idx     (wr_idx),
    .wr_data    (in_data_in),
    .tap_first  (tap_first),
    .tap_second (tap_second),
    .tap_penult (tap_penult),
    .tap_last   (tap_last)
  );

  // Command decode and ring control.
  always_comb begin
    state_nxt   = state_r;
    anchor_nxt  = anchor_r;
    count_nxt   = count_r;
    rem_nxt     = rem_r;
    ctrl.shift  = SH_HOLD;
    ctrl.wr_en  = 1'b0;
    wr_idx      = '0;
    done        = 1'b0;
    res_data    = '0;
    res_status  = STATUS_OK;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
              done = 1'b1;
              if (full) begin
                res_status = STATUS_OVERFLOW;
              end else begin
                count_nxt  = count_r + CNT_W'(1);
                ctrl.wr_en = 1'b1;
                if (cmd == CMD_PUSH_FRONT) begin
                  if (anchor_r == ANCHOR_FRONT) begin
                    ctrl.shift = SH_RIGHT;
                    wr_idx     = '0;
                  end else begin
                    wr_idx = LAST_IDX - IDX_W'(count_r);
                  end
                end else begin
                  if (anchor_r == ANCHOR_FRONT) begin
                    wr_idx = IDX_W'(count_r);
                  end else begin
                    ctrl.shift = SH_LEFT;
                    wr_idx     = LAST_IDX;
                  end
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
              if (empty) begin
                done       = 1'b1;
                res_status = STATUS_UNDERFLOW;
                res_data   = '1;
              end else if ((anchor_r == ANCHOR_FRONT) && (cmd == CMD_POP_FRONT)) begin
                done       = 1'b1;
                res_data   = tap_first;
                ctrl.shift = SH_LEFT;
                count_nxt  = count_r - CNT_W'(1);
              end else if ((anchor_r == ANCHOR_REAR) && (cmd == CMD_POP_REAR)) begin
                done       = 1'b1;
                res_data   = tap_last;
                ctrl.shift = SH_RIGHT;
                count_nxt  = count_r - CNT_W'(1);
              end else if (count_r == CNT_W'(1)) begin
                // A single entry is both ends at once.
                done      = 1'b1;
                res_data  = (anchor_r == ANCHOR_FRONT) ? tap_first : tap_last;
                count_nxt = '0;
              end else begin
                // Far end: rotate that word round to the end cell.
                state_nxt = ST_ROTATE;
                rem_nxt   = IDX_W'(count_r - CNT_W'(1));
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROTATE: begin
        ctrl.shift = (anchor_r == ANCHOR_FRONT) ? SH_LEFT : SH_RIGHT;
        rem_nxt    = rem_r - IDX_W'(1);
        if (rem_r == IDX_W'(1)) begin
          // Last step: the word arrives in the end cell and is taken out.
          done       = 1'b1;
          res_data   = (anchor_r == ANCHOR_FRONT) ? tap_second : tap_penult;
          count_nxt  = count_r - CNT_W'(1);
          anchor_nxt = (anchor_r == ANCHOR_FRONT) ? ANCHOR_REAR : ANCHOR_FRONT;
          state_nxt  = ST_IDLE;
        end
      end
      default: ;
    endcase
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_nxt};

  // State, counters and the result beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      anchor_r    <= ANCHOR_FRONT;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      anchor_r    <= anchor_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= done;
    end
    if (done) begin
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_count_r  <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  assign busy            = (state_r == ST_ROTATE);
  assign out_valid       = out_valid_r;
  assign out_data_out    = out_data_r;
  assign out_status      = out_status_r;
  assign out_count_after = out_count_r;

  // A far-end rotation only starts with at least two entries held.
  `CD_ASSERT_HOLDS(a_rotate_needs_two, clk, rst_n, busy |-> (count_r >= CNT_W'(2)), "rotation with fewer than two entries")

  // The entry count never passes the ring size.
  `CD_ASSERT_HOLDS(a_count_bound, clk, rst_n, count_r <= FULL_CNT, "entry count above depth")

  // An overflow result leaves the deque full.
  `CD_ASSERT_HOLDS(a_overflow_full, clk, rst_n, (out_valid && (out_status == STATUS_OVERFLOW)) |-> full, "overflow reported while not full")

  // An underflow result leaves the deque empty and returns all ones.
  `CD_ASSERT_HOLDS(a_underflow_empty, clk, rst_n, (out_valid && (out_status == STATUS_UNDERFLOW)) |-> (empty && (out_data_r == '1)), "bad underflow result")

  // The last rotation step ends the item and frees the command port.
  `CD_ASSERT_NEXT(a_rotate_ends, clk, rst_n, busy && (rem_r == IDX_W'(1)), !busy && out_valid, "rotation did not complete")

endmodule

`default_nettype wire

// ===== rtl/core/cd_cell.sv =====
// ----------------------------------------------------------------------------
// Circular deque storage cell
// Holds one word of the ring. Each cycle it keeps its word, takes the word
// of either neighbour, or loads the write word when the write index is its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_cell #(
  parameter int IDX_W = 7,
  parameter int INDEX = 0
) (
  input  wire logic                      clk,
  input  wire cd_pkg::cell_ctrl_t        ctrl,
  input  wire logic [IDX_W-1:0]          wr_idx,
  input  wire logic [cd_pkg::WORD_W-1:0] wr_data,
  input  wire logic [cd_pkg::WORD_W-1:0] left_in,
  input  wire logic [cd_pkg::WORD_W-1:0] right_in,
  output logic      [cd_pkg::WORD_W-1:0] data_q
);

  import cd_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  // Neighbour hand-over first; a write aimed at this cell takes precedence.
  always_comb begin
    unique case (ctrl.shift)
      SH_LEFT:  data_nxt = right_in;
      SH_RIGHT: data_nxt = left_in;
      SH_HOLD:  data_nxt = data_r;
      default:  data_nxt = data_r;
    endcase
    if (ctrl.wr_en && (wr_idx == IDX_W'(INDEX))) begin
      data_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

`default_nettype wire

// ===== rtl/core/cd_chain.sv =====
// ----------------------------------------------------------------------------
// Circular deque cell ring
// A closed ring of DEPTH cells. Shifting left moves every word one cell
// towards index 0, shifting right one cell away from it; the ends wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_chain #(
  parameter int DEPTH = 128,
  parameter int IDX_W = 7
) (
  input  wire logic                      clk,
  input  wire cd_pkg::cell_ctrl_t        ctrl,
  input  wire logic [IDX_W-1:0]          wr_idx,
  input  wire logic [cd_pkg::WORD_W-1:0] wr_data,
  output logic      [cd_pkg::WORD_W-1:0] tap_first,
  output logic      [cd_pkg::WORD_W-1:0] tap_second,
  output logic      [cd_pkg::WORD_W-1:0] tap_penult,
  output logic      [cd_pkg::WORD_W-1:0] tap_last
);

  import cd_pkg::*;

  logic [WORD_W-1:0] cell_q [DEPTH];

  // Each cell sees its two ring neighbours.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int LEFT_IDX  = (i == 0) ? DEPTH - 1 : i - 1;
    localparam int RIGHT_IDX = (i == DEPTH - 1) ? 0 : i + 1;

    cd_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .wr_idx   (wr_idx),
      .wr_data  (wr_data),
      .left_in  (cell_q[LEFT_IDX]),
      .right_in (cell_q[RIGHT_IDX]),
      .data_q   (cell_q[i])
    );
  end

  // Fixed taps at both ends of the ring.
  assign tap_first  = cell_q[0];
  assign tap_second = cell_q[1];
  assign tap_penult = cell_q[DEPTH-2];
  assign tap_last   = cell_q[DEPTH-1];

endmodule

`default_nettype wire

// ===== dv/deque_checker.sv =====
// ----------------------------------------------------------------------------
// Circular deque result checker
// Watches the command and result channels of the deque. Each accepted command
// beat runs through a local model of the deque, and the predicted result is
// queued. Each result beat is compared field by field with the oldest
// prediction. Mismatch and outstanding counts go back to the testbench top.
// ----------------------------------------------------------------------------
module deque_checker
  import cd_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic        [CMD_W-1:0]       in_command,
  input  logic signed [WORD_W-1:0]      in_data_in,
  input  logic                          out_valid,
  input  logic signed [WORD_W-1:0]      out_data_out,
  input  logic        [STATUS_W-1:0]    out_status,
  input  logic        [COUNT_OUT_W-1:0] out_count_after,
  output int                            error_count,
  output int                            pending_results
);

  // One predicted result beat.
  typedef struct packed {
    logic signed [WORD_W-1:0]      word;
    logic        [STATUS_W-1:0]    status;
    logic        [COUNT_OUT_W-1:0] held;
  } deque_result_t;

  // Local copy of the deque contents and its two ends.
  logic signed [WORD_W-1:0] slot_word [DEPTH];
  int unsigned              head_slot;
  int unsigned              tail_slot;
  int unsigned              held_words;

  deque_result_t expected_q [$];
  int unsigned   mismatches;
  int unsigned   results_seen;

  // Apply one command to the local deque and return the result it gives.
  function automatic deque_result_t deque_apply(cmd_t cmd, logic signed [WORD_W-1:0] word);
    deque_result_t r;
    r.word   = '0;
    r.status = STATUS_OK;
    if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
      if (held_words >= DEPTH) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        // A push onto an empty deque always lands in slot 0.
        if (held_words == 0) begin
          head_slot    = 0;
          tail_slot    = 0;
          slot_word[0] = word;
        end else if (cmd == CMD_PUSH_FRONT) begin
          head_slot            = (head_slot + DEPTH - 1) % DEPTH;
          slot_word[head_slot] = word;
        end else begin
          tail_slot            = (tail_slot + 1) % DEPTH;
          slot_word[tail_slot] = word;
        end
        held_words++;
      end
    end else begin
      if (held_words == 0) begin
        r.status = STATUS_UNDERFLOW;
        r.word   = -1;
      end else begin
        r.word = (cmd == CMD_POP_FRONT) ? slot_word[head_slot] : slot_word[tail_slot];
        // Taking the last word sends both ends back to slot 0.
        if (held_words == 1) begin
          head_slot = 0;
          tail_slot = 0;
        end else if (cmd == CMD_POP_FRONT) begin
          head_slot = (head_slot + 1) % DEPTH;
        end else begin
          tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
        end
        held_words--;
      end
    end
    r.held = COUNT_OUT_W'(held_words);
    return r;
  endfunction

  // Check result beats first, then predict the command beat of the same edge:
  // a result can never belong to a command taken at the same edge.
  always @(posedge clk) begin : watch
    deque_result_t exp_r;
    if (!rst_n) begin
      expected_q.delete();
      head_slot    = 0;
      tail_slot    = 0;
      held_words   = 0;
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (out_valid) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result beat %0d with nothing outstanding: data %0d status %0d count %0d",
                     $realtime, results_seen, out_data_out, out_status, out_count_after);
          end
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data_out !== exp_r.word || out_status !== exp_r.status ||
              out_count_after !== exp_r.held) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result beat %0d mismatch: expected data %0d status %0d count %0d, got data %0d status %0d count %0d",
                       $realtime, results_seen, exp_r.word, exp_r.status, exp_r.held,
                       out_data_out, out_status, out_count_after);
            end
          end
        end
      end
      if (start && !busy) begin
        expected_q.push_back(deque_apply(cmd_t'(in_command), in_data_in));
      end
    end
    error_count     <= mismatches;
    pending_results <= expected_q.size();
  end

endmodule

// ===== dv/tb_circular_deque.sv =====
// ----------------------------------------------------------------------------
// Circular deque testbench
// Drives command beats into the deque: a short directed run over empty pops,
// extreme words and both ends, then three random phases that each fill the
// deque past full, mix pushes and pops, and drain it past empty, under
// different amounts of sender idling. A separate checker predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module tb_circular_deque;

  import cd_pkg::*;

  localparam int DEPTH        = 128;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_BEATS  = 467;
  localparam int SETTLE_TICKS = 16;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic        [CMD_W-1:0]       in_command;
  logic signed [WORD_W-1:0]      in_data_in;
  logic                          out_valid;
  logic signed [WORD_W-1:0]      out_data_out;
  logic        [STATUS_W-1:0]    out_status;
  logic        [COUNT_OUT_W-1:0] out_count_after;

  int          error_count;
  int          pending_results;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned level = 0;
  int unsigned full_pushes = 0;
  int unsigned empty_pops = 0;

  circular_deque #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_count_after(out_count_after)
  );

  deque_checker #(
    .DEPTH(DEPTH)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_count_after(out_count_after),
    .error_count    (error_count),
    .pending_results(pending_results)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_results);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one command beat and hold it until the deque takes it. The start
  // line is left high so that a following beat can go out on the next edge.
  task automatic send_beat(input cmd_t cmd, input logic signed [WORD_W-1:0] word);
    start      <= 1'b1;
    in_command <= cmd;
    in_data_in <= word;
    do @(posedge clk); while (busy);
    beats_sent++;
    // Occupancy is tracked only to steer the stimulus.
    if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
      if (level == DEPTH) full_pushes++;
      else level++;
    end else begin
      if (level == 0) empty_pops++;
      else level--;
    end
  endtask

  // Drop start for a geometric number of cycles, idle_pct in a hundred.
  task automatic idle_gap(input int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start      <= 1'b0;
      in_data_in <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every result beat has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results != 0 || busy);
  endtask

  // Random word, with the extremes picked often.
  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // One random beat: a push with push_pct in a hundred, at a random end.
  task automatic random_beat(input int push_pct, input int idle_pct);
    cmd_t cmd;
    if ($urandom_range(99) < push_pct) begin
      cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    end else begin
      cmd = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
    end
    send_beat(cmd, random_word());
    idle_gap(idle_pct);
  endtask

  // Fill past full, wander at random, then drain past empty.
  task automatic run_phase(input int idle_pct, input int budget);
    int unsigned first_beat;
    int          push_pct;
    first_beat = beats_sent;
    while (level < DEPTH) random_beat(85, idle_pct);
    repeat ($urandom_range(3, 1)) random_beat(100, idle_pct);
    while (beats_sent - first_beat + level + 3 < budget) begin
      push_pct = $urandom_range(75, 25);
      repeat ($urandom_range(40, 10)) random_beat(push_pct, idle_pct);
    end
    while (level > 0) random_beat(15, idle_pct);
    repeat ($urandom_range(3, 1)) random_beat(0, idle_pct);
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_command <= CMD_PUSH_FRONT;
    in_data_in <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pops on an empty deque, extreme words at both ends, pops
    // from the anchored and the far end, and taking the last word.
    send_beat(CMD_POP_FRONT,  32'sh1234_5678);
    send_beat(CMD_POP_REAR,   32'sh7FFF_FFFF);
    send_beat(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_beat(CMD_POP_REAR,   '0);
    send_beat(CMD_PUSH_REAR,  32'sh8000_0000);
    send_beat(CMD_PUSH_FRONT, -1);
    send_beat(CMD_PUSH_REAR,  '0);
    send_beat(CMD_PUSH_FRONT, 32'sh0000_0001);
    send_beat(CMD_POP_REAR,   -1);
    send_beat(CMD_POP_FRONT,  '0);
    send_beat(CMD_POP_FRONT,  '0);
    send_beat(CMD_PUSH_FRONT, 32'sh5A5A_5A5A);
    send_beat(CMD_POP_REAR,   '0);
    send_beat(CMD_POP_REAR,   '0);
    send_beat(CMD_POP_FRONT,  '0);
    send_beat(CMD_PUSH_REAR,  32'shA5A5_A5A5);
    send_beat(CMD_POP_FRONT,  '0);
    send_beat(CMD_POP_REAR,   '0);
    wait_drained();

    // Random phases: light sender idling, heavy idling, then none.
    run_phase(16, PHASE_BEATS);
    wait_drained();
    run_phase(73, PHASE_BEATS);
    wait_drained();
    run_phase(0, PHASE_BEATS);
    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Sent %0d command beats over directed, light-idle, heavy-idle and back-to-back runs,",
             beats_sent);
    $display("including %0d pushes on a full deque and %0d pops on an empty one.",
             full_pushes, empty_pops);
    if (error_count == 0 && pending_results == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
